// ----- rtl/ptpstg_pkg.sv -----
// Shared constants and types for the PTP system time generator.
package ptpstg_pkg;

	localparam int unsigned ACCUMULATOR_BITS_DEFAULT = 32;

	localparam int unsigned SEC_W   = 32;
	localparam int unsigned NS_W    = 30;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned ADDEND_W = 32;
	localparam int unsigned SUBSEC_W = 8;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [NS_W-1:0] NS_ROLLOVER = 30'd1000000000;
	localparam logic [NS_W-1:0] NS_MAX      = 30'd999999999;

	localparam logic [ADDEND_W-1:0] BASE_ADDEND_RESET = 32'd1988410785;
	localparam logic [SUBSEC_W-1:0] SUBSEC_RESET      = 8'd10;

	// Register index, taken from paddr[2].
	localparam logic REG_BASE_ADDEND = 1'b0;
	localparam logic REG_SUBSEC_INC  = 1'b1;

	localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
	localparam logic [OP_W-1:0] OP_ADJUST  = 3'd1;
	localparam logic [OP_W-1:0] OP_SET     = 3'd2;
	localparam logic [OP_W-1:0] OP_UPDATE  = 3'd3;
	localparam logic [OP_W-1:0] OP_ARM     = 3'd4;
	localparam logic [OP_W-1:0] OP_DISARM  = 3'd5;
	localparam logic [OP_W-1:0] OP_READ    = 3'd6;

	// Item as it enters the state-update stage.
	typedef struct packed {
		logic [OP_W-1:0]     opcode;
		logic [SEC_W-1:0]    seconds;
		logic [NS_W-1:0]     ns_sat;
		logic [NS_W-1:0]     ns_raw;
		logic                negative;
		logic [ADDEND_W-1:0] prod_hi;
	} s2_item_t;

endpackage

// ----- rtl/ptp_system_time_generator.sv -----
// PTP system time generator: decimal mode with fine correction, APB configuration.
//
//  channel | signals                                              | role
//  --------+------------------------------------------------------+------------------------
//  in      | in_valid, in_ready, opcode, time_seconds,            | command transfer
//          | time_nanoseconds, negative, correction               |
//  out     | out_valid, out_ready, now_seconds, now_nanoseconds,  | time after each command
//          | trigger, target_armed                                |
//  apb     | psel, penable, pwrite, paddr, pwdata, prdata, pready | configuration registers
//
// A command's reading passes an input register, a stage that forms the speed-correction
// product (one 33x33 signed multiplier), and a stage that updates the time state and loads
// the output register. A command is accepted in every cycle while the output is not
// blocked, so a continuous stream of ticks advances the accumulator once per cycle.
// Reset is asynchronous and active low; it zeroes time, accumulator and target and loads
// the nominal addend. A blocked output holds its stage; in_ready drops once all are full.
module ptp_system_time_generator #(
	parameter int unsigned ACCUMULATOR_BITS = ptpstg_pkg::ACCUMULATOR_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [ptpstg_pkg::OP_W-1:0]        opcode,
	input  logic [ptpstg_pkg::SEC_W-1:0]       time_seconds,
	input  logic [ptpstg_pkg::NS_W-1:0]        time_nanoseconds,
	input  logic                               negative,
	input  logic signed [31:0]                 correction,

	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ptpstg_pkg::SEC_W-1:0]       now_seconds,
	output logic [ptpstg_pkg::NS_W-1:0]        now_nanoseconds,
	output logic                               trigger,
	output logic                               target_armed,

	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [ptpstg_pkg::PADDR_W-1:0]     paddr,
	input  logic [ptpstg_pkg::PDATA_W-1:0]     pwdata,
	output logic [ptpstg_pkg::PDATA_W-1:0]     prdata,
	output logic                               pready
);

	localparam int unsigned AW = ACCUMULATOR_BITS;

	// Configuration registers.
	logic [ptpstg_pkg::ADDEND_W-1:0] base_addend_q;
	logic [ptpstg_pkg::SUBSEC_W-1:0] subsec_inc_q;
	logic                            cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addend_q <= ptpstg_pkg::BASE_ADDEND_RESET;
			subsec_inc_q  <= ptpstg_pkg::SUBSEC_RESET;
		end else if (cfg_write) begin
			unique case (paddr[2])
				ptpstg_pkg::REG_BASE_ADDEND: base_addend_q <= pwdata;
				ptpstg_pkg::REG_SUBSEC_INC:  subsec_inc_q  <= pwdata[ptpstg_pkg::SUBSEC_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			ptpstg_pkg::REG_BASE_ADDEND: prdata = base_addend_q;
			ptpstg_pkg::REG_SUBSEC_INC:
				prdata = {{(ptpstg_pkg::PDATA_W-ptpstg_pkg::SUBSEC_W){1'b0}}, subsec_inc_q};
			default: prdata = '0;
		endcase
	end

	// Pipeline flow control. Each stage advances when the stage after it is empty
	// or is moving on in the same cycle.
	logic s1_v_q, s2_v_q, out_v_q;
	logic en_out, en2, en1;

	assign en_out   = !out_v_q || out_ready;
	assign en2      = !s2_v_q || en_out;
	assign en1      = !s1_v_q || en2;
	assign in_ready = en1;

	// Stage 1: input register.
	logic [ptpstg_pkg::OP_W-1:0]  opcode_s1;
	logic [ptpstg_pkg::SEC_W-1:0] seconds_s1;
	logic [ptpstg_pkg::NS_W-1:0]  ns_s1;
	logic                         negative_s1;
	logic signed [31:0]           correction_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (en1) begin
			s1_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1     <= opcode;
			seconds_s1    <= time_seconds;
			ns_s1         <= time_nanoseconds;
			negative_s1   <= negative;
			correction_s1 <= correction;
		end
	end

	// Speed correction product base * sext(correction); the upper half of the low
	// 64 bits is the fractional adjustment of the addend.
	logic signed [32:0] base_signed;
	logic signed [32:0] corr_signed;
	logic signed [65:0] product;
	ptpstg_pkg::s2_item_t item_s1;

	assign base_signed = $signed({1'b0, base_addend_q});
	assign corr_signed = $signed({correction_s1[31], correction_s1});
	assign product     = base_signed * corr_signed;

	always_comb begin
		item_s1.opcode   = opcode_s1;
		item_s1.seconds  = seconds_s1;
		item_s1.ns_raw   = ns_s1;
		item_s1.ns_sat   = (ns_s1 >= ptpstg_pkg::NS_ROLLOVER) ? ptpstg_pkg::NS_MAX : ns_s1;
		item_s1.negative = negative_s1;
		item_s1.prod_hi  = product[63:32];
	end

	// Stage 2 register.
	ptpstg_pkg::s2_item_t item_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (en2) begin
			s2_v_q <= s1_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && s1_v_q) begin
			item_s2 <= item_s1;
		end
	end

	// Time state.
	logic [AW-1:0]                   acc_q, acc_n;
	logic [ptpstg_pkg::ADDEND_W-1:0] addend_q, addend_n;
	logic [ptpstg_pkg::SEC_W-1:0]    sec_q, sec_n;
	logic [ptpstg_pkg::NS_W-1:0]     ns_q, ns_n;
	logic [ptpstg_pkg::SEC_W-1:0]    tsec_q, tsec_n;
	logic [ptpstg_pkg::NS_W-1:0]     tns_q, tns_n;
	logic                            armed_q, armed_n;
	logic                            trig_n;

	// Addend bits above the accumulator width are dropped; a wider accumulator
	// sees the addend zero-extended.
	logic [63:0]                  addend_wide;
	logic [AW-1:0]                addend_acc;
	logic [AW:0]                  acc_sum;
	logic [ptpstg_pkg::NS_W:0]    tick_ns;
	logic [ptpstg_pkg::NS_W:0]    upd_sum;
	logic [ptpstg_pkg::NS_W:0]    upd_diff;
	logic [ptpstg_pkg::NS_W:0]    rollover_w;

	assign addend_wide = {32'b0, addend_q};
	assign addend_acc  = addend_wide[AW-1:0];
	assign acc_sum     = {1'b0, acc_q} + {1'b0, addend_acc};
	assign rollover_w  = {1'b0, ptpstg_pkg::NS_ROLLOVER};
	assign tick_ns     = {1'b0, ns_q} +
		{{(ptpstg_pkg::NS_W+1-ptpstg_pkg::SUBSEC_W){1'b0}}, subsec_inc_q};
	assign upd_sum     = {1'b0, ns_q} + {1'b0, item_s2.ns_sat};
	assign upd_diff    = {1'b0, ns_q} - {1'b0, item_s2.ns_sat};

	always_comb begin
		acc_n    = acc_q;
		addend_n = addend_q;
		sec_n    = sec_q;
		ns_n     = ns_q;
		tsec_n   = tsec_q;
		tns_n    = tns_q;
		armed_n  = armed_q;
		trig_n   = 1'b0;

		unique case (item_s2.opcode)
			ptpstg_pkg::OP_TICK: begin
				acc_n = acc_sum[AW-1:0];
				if (acc_sum[AW]) begin
					if (tick_ns >= rollover_w) begin
						ns_n  = tick_ns[ptpstg_pkg::NS_W-1:0] - ptpstg_pkg::NS_ROLLOVER;
						sec_n = sec_q + 32'd1;
					end else begin
						ns_n = tick_ns[ptpstg_pkg::NS_W-1:0];
					end
				end
			end
			ptpstg_pkg::OP_ADJUST: begin
				addend_n = base_addend_q + item_s2.prod_hi;
			end
			ptpstg_pkg::OP_SET: begin
				sec_n = item_s2.seconds;
				ns_n  = item_s2.ns_sat;
			end
			ptpstg_pkg::OP_UPDATE: begin
				if (!item_s2.negative) begin
					if (upd_sum >= rollover_w) begin
						ns_n  = upd_sum[ptpstg_pkg::NS_W-1:0] - ptpstg_pkg::NS_ROLLOVER;
						sec_n = sec_q + item_s2.seconds + 32'd1;
					end else begin
						ns_n  = upd_sum[ptpstg_pkg::NS_W-1:0];
						sec_n = sec_q + item_s2.seconds;
					end
				end else begin
					// A negative difference borrows one second; adding the rollover
					// modulo 2^30 lands back inside the nanosecond range.
					if (upd_diff[ptpstg_pkg::NS_W]) begin
						ns_n  = upd_diff[ptpstg_pkg::NS_W-1:0] + ptpstg_pkg::NS_ROLLOVER;
						sec_n = sec_q - item_s2.seconds - 32'd1;
					end else begin
						ns_n  = upd_diff[ptpstg_pkg::NS_W-1:0];
						sec_n = sec_q - item_s2.seconds;
					end
				end
			end
			ptpstg_pkg::OP_ARM: begin
				tsec_n  = item_s2.seconds;
				tns_n   = item_s2.ns_raw;
				armed_n = 1'b1;
			end
			ptpstg_pkg::OP_DISARM: begin
				armed_n = 1'b0;
			end
			default: ;
		endcase

		if (armed_n && ((sec_n > tsec_n) || ((sec_n == tsec_n) && (ns_n >= tns_n)))) begin
			trig_n  = 1'b1;
			armed_n = 1'b0;
		end
	end

	logic state_en;
	assign state_en = s2_v_q && en_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q    <= '0;
			addend_q <= ptpstg_pkg::BASE_ADDEND_RESET;
			sec_q    <= '0;
			ns_q     <= '0;
			tsec_q   <= '0;
			tns_q    <= '0;
			armed_q  <= 1'b0;
		end else if (state_en) begin
			acc_q    <= acc_n;
			addend_q <= addend_n;
			sec_q    <= sec_n;
			ns_q     <= ns_n;
			tsec_q   <= tsec_n;
			tns_q    <= tns_n;
			armed_q  <= armed_n;
		end
	end

	// Output register.
	logic [ptpstg_pkg::SEC_W-1:0] out_sec_q;
	logic [ptpstg_pkg::NS_W-1:0]  out_ns_q;
	logic                         out_trig_q;
	logic                         out_armed_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= s2_v_q;
		end
	end

	always_ff @(posedge clk) begin
		if (state_en) begin
			out_sec_q   <= sec_n;
			out_ns_q    <= ns_n;
			out_trig_q  <= trig_n;
			out_armed_q <= armed_n;
		end
	end

	assign out_valid       = out_v_q;
	assign now_seconds     = out_sec_q;
	assign now_nanoseconds = out_ns_q;
	assign trigger         = out_trig_q;
	assign target_armed    = out_armed_q;

	// The input side only stalls when the output transfer is blocked.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_v_q && !out_ready))
		else $error("input stalled while output was free");

	// The clock's nanoseconds never leave their range.
	a_ns_range: assert property (@(posedge clk) disable iff (!arst_n)
		ns_q < ptpstg_pkg::NS_ROLLOVER)
		else $error("nanoseconds out of range");

	// A trigger disarms the target for the following commands.
	a_trig_disarm: assert property (@(posedge clk) disable iff (!arst_n)
		(state_en && trig_n) |=> (!armed_q && out_v_q && out_trig_q && !out_armed_q))
		else $error("target still armed after trigger");

endmodule
